// File: sv/tun_pkg.sv
`timescale 1ns / 1ps
package tun_pkg;
   localparam int VERTEX_DEPTH = 1024;
   localparam int SLOT_W = 10;
   localparam int ADDR_W = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
   localparam int COORD_W = 24;
   localparam int UNIT_W = 16;
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_TRI = 1'b1;

   typedef struct packed {
      logic                      req_type;
      logic [SLOT_W-1:0]         vertex_slot;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [SLOT_W-1:0]         corner_a;
      logic [SLOT_W-1:0]         corner_b;
      logic [SLOT_W-1:0]         corner_c;
   } req_word_type;

   typedef struct packed {
      logic signed [UNIT_W-1:0] unit_x;
      logic signed [UNIT_W-1:0] unit_y;
      logic signed [UNIT_W-1:0] unit_z;
      logic                     degenerate;
   } rsp_word_type;
endpackage

// File: sv/tun_if.sv
`timescale 1ns / 1ps
interface tun_req_if;
   logic                  valid;
   logic                  ready;
   tun_pkg::req_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tun_rsp_if;
   logic                  valid;
   logic                  ready;
   tun_pkg::rsp_word_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: sv/triangle_unit_normal.sv
`timescale 1ns / 1ps
// Triangle face normal from a 1024-entry vertex store (one RAM with separate
// read and write addresses, 72-bit words, registered read). A load word writes a
// vertex when it is taken and gives no result. A triangle word reads its three
// corners in turn and builds the cross product with one shared 26x26 multiplier.
// It then scales the magnitudes below 2^30 one bit a cycle and sums the three
// squares on a 30x30 squarer. A 31-step bit-pair square root and three restoring
// divisions follow. Most of the time to a result goes to the square root and
// divide loops. A degenerate triangle gives its all-zero result from the scaling
// state, without the squares, root or divisions. The next word is taken once the
// result register has been read. Reading a never-loaded vertex gives an
// undefined normal.
module triangle_unit_normal (
   input logic clock,
   input logic reset,
   tun_req_if.sink   req_if,
   tun_rsp_if.source rsp_if
);
   import tun_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD, ST_MUL, ST_SHIFT, ST_SQ, ST_SQRT, ST_DIV, ST_OUT
   } state_type;

   state_type state_ff;
   logic [COORD_W*3-1:0] mem [VERTEX_DEPTH];
   logic [COORD_W*3-1:0] rdata_ff;
   logic [ADDR_W-1:0]    raddr;
   logic [1:0]           cnt_ff;
   logic [2:0]           oob_ff;
   logic [SLOT_W-1:0]    ca_ff, cb_ff, cc_ff;
   logic signed [COORD_W-1:0] va_ff [3];
   logic signed [COORD_W-1:0] vb_ff [3];
   logic signed [25:0]   u_ff [3];
   logic signed [25:0]   v_ff [3];
   logic signed [52:0]   n_ff [3];
   logic [2:0]           neg_ff;
   logic [50:0]          mag_ff [3];
   logic [29:0]          a_ff [3];
   logic [62:0]          sum_ff;
   logic [63:0]          rem_ff;
   logic [31:0]          root_ff;
   logic [5:0]           step_ff;
   logic [44:0]          drem_ff;
   logic [14:0]          q_ff;
   logic [1:0]           comp_ff;
   logic [3:0]           mstep_ff;
   logic [UNIT_W-1:0]    res_ff [3];
   logic                 deg_ff;
   logic                 ovalid_ff;

   logic signed [25:0]   ma, mb;
   logic signed [51:0]   prod;
   logic                 take;

   assign take = req_if.valid && req_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign rsp_if.valid = ovalid_ff;
   assign rsp_if.data.unit_x = res_ff[0];
   assign rsp_if.data.unit_y = res_ff[1];
   assign rsp_if.data.unit_z = res_ff[2];
   assign rsp_if.data.degenerate = deg_ff;

   function automatic logic fits(input logic [SLOT_W-1:0] i);
      fits = ({22'd0, i} < 32'(VERTEX_DEPTH));
   endfunction

   always_comb begin
      case (cnt_ff)
         2'd0: raddr = ca_ff[ADDR_W-1:0];
         2'd1: raddr = cb_ff[ADDR_W-1:0];
         default: raddr = cc_ff[ADDR_W-1:0];
      endcase
   end

   // shared multiplier for the cross-product terms
   always_comb begin
      ma = '0;
      mb = '0;
      if (state_ff == ST_MUL) begin
         case (mstep_ff)
            4'd0: begin ma = u_ff[1]; mb = v_ff[2]; end
            4'd1: begin ma = u_ff[2]; mb = v_ff[1]; end
            4'd2: begin ma = u_ff[2]; mb = v_ff[0]; end
            4'd3: begin ma = u_ff[0]; mb = v_ff[2]; end
            4'd4: begin ma = u_ff[0]; mb = v_ff[1]; end
            default: begin ma = u_ff[1]; mb = v_ff[0]; end
         endcase
      end
   end
   assign prod = ma * mb;

   logic [59:0] sq;
   logic [29:0] sq_in;
   always_comb begin
      case (comp_ff)
         2'd0: sq_in = a_ff[0];
         2'd1: sq_in = a_ff[1];
         default: sq_in = a_ff[2];
      endcase
   end
   assign sq = sq_in * sq_in;

   logic [50:0] m_max;
   always_comb begin
      m_max = mag_ff[0];
      if (mag_ff[1] > m_max) m_max = mag_ff[1];
      if (mag_ff[2] > m_max) m_max = mag_ff[2];
   end

   // square root step; the sum stays below 2^62
   logic [63:0] trial;
   logic [63:0] rem_next;
   logic [65:0] rem_sh;
   always_comb begin
      rem_sh = {rem_ff, sum_ff[61-:2]} ;
      trial = {30'd0, root_ff, 2'b01} ;
      rem_next = rem_sh[63:0];
   end

   logic [44:0] dsh;
   always_comb begin
      dsh = 45'(root_ff) << (4'd15 - step_ff[3:0]);
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (take && req_if.data.req_type == REQ_LOAD && fits(req_if.data.vertex_slot))
         mem[req_if.data.vertex_slot[ADDR_W-1:0]] <=
            {req_if.data.pos_x, req_if.data.pos_y, req_if.data.pos_z};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ovalid_ff <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) ovalid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (take && req_if.data.req_type == REQ_TRI) begin
                  ca_ff <= req_if.data.corner_a;
                  cb_ff <= req_if.data.corner_b;
                  cc_ff <= req_if.data.corner_c;
                  oob_ff <= {!fits(req_if.data.corner_c), !fits(req_if.data.corner_b),
                             !fits(req_if.data.corner_a)};
                  cnt_ff <= 2'd0;
                  state_ff <= ST_RD;
               end
            end
            ST_RD: begin
               // data for corner cnt-1 lands now
               cnt_ff <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd1) begin
                  va_ff[0] <= oob_ff[0] ? '0 : rdata_ff[71:48];
                  va_ff[1] <= oob_ff[0] ? '0 : rdata_ff[47:24];
                  va_ff[2] <= oob_ff[0] ? '0 : rdata_ff[23:0];
               end
               if (cnt_ff == 2'd2) begin
                  vb_ff[0] <= oob_ff[1] ? '0 : rdata_ff[71:48];
                  vb_ff[1] <= oob_ff[1] ? '0 : rdata_ff[47:24];
                  vb_ff[2] <= oob_ff[1] ? '0 : rdata_ff[23:0];
               end
               if (cnt_ff == 2'd3) begin
                  for (int i = 0; i < 3; i++) begin
                     u_ff[i] <= 26'(vb_ff[i]) - 26'(va_ff[i]);
                     v_ff[i] <= 26'(oob_ff[2] ? 24'sd0 : $signed(rdata_ff[71-24*i -: 24]))
                                - 26'(va_ff[i]);
                  end
                  mstep_ff <= 4'd0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mstep_ff[0] == 1'b0) n_ff[mstep_ff[2:1]] <= 53'(prod);
               else n_ff[mstep_ff[2:1]] <= n_ff[mstep_ff[2:1]] - 53'(prod);
               if (mstep_ff == 4'd5) state_ff <= ST_SHIFT;
               mstep_ff <= (mstep_ff == 4'd5) ? 4'd0 : mstep_ff + 4'd1;
            end
            ST_SHIFT: begin
               if (mstep_ff == 4'd0) begin
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= n_ff[i][52];
                     mag_ff[i] <= n_ff[i][52] ? 51'(-n_ff[i]) : 51'(n_ff[i]);
                  end
                  mstep_ff <= 4'd1;
               end else if (m_max == '0) begin
                  for (int i = 0; i < 3; i++) res_ff[i] <= '0;
                  deg_ff <= 1'b1;
                  ovalid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else if (m_max[50:30] != '0) begin
                  // one bit a cycle
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
               end else begin
                  for (int i = 0; i < 3; i++) a_ff[i] <= mag_ff[i][29:0];
                  sum_ff <= '0;
                  comp_ff <= 2'd0;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               sum_ff <= sum_ff + 63'(sq);
               comp_ff <= comp_ff + 2'd1;
               if (comp_ff == 2'd2) begin
                  rem_ff <= '0;
                  root_ff <= '0;
                  step_ff <= '0;
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               // two radicand bits per step, MSB first
               if ({2'b0, rem_next} >= {2'b0, trial}) begin
                  rem_ff <= rem_next - trial;
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= rem_next;
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               sum_ff <= {sum_ff[60:0], 2'b00};
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'd30) begin
                  comp_ff <= 2'd0;
                  step_ff <= '0;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (step_ff == 6'd0) begin
                  drem_ff <= {1'b0, a_ff[comp_ff], 14'd0} + 45'(root_ff[31:1]);
                  q_ff <= '0;
                  step_ff <= 6'd1;
               end else if (step_ff <= 6'd15) begin
                  // quotient at most 16384: 15 bits, bit 14 first
                  if (drem_ff >= dsh) begin
                     drem_ff <= drem_ff - dsh;
                     q_ff <= {q_ff[13:0], 1'b1};
                  end else q_ff <= {q_ff[13:0], 1'b0};
                  step_ff <= step_ff + 6'd1;
               end else begin
                  res_ff[comp_ff] <= neg_ff[comp_ff] ? -{1'b0, q_ff} : {1'b0, q_ff};
                  step_ff <= '0;
                  comp_ff <= comp_ff + 2'd1;
                  if (comp_ff == 2'd2) state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               deg_ff <= 1'b0;
               ovalid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: sv/tun_check.sv
`timescale 1ns / 1ps
module tun_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_deg,
   input logic [15:0] rsp_x
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_deg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_deg |-> rsp_x == 16'd0) else $error("degenerate nonzero");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("accept while result pending");
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("result right after accept");
endmodule

bind triangle_unit_normal tun_check u_check (
   .clock(clock), .reset(reset),
   .req_valid(req_if.valid), .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
   .rsp_deg(rsp_if.data.degenerate), .rsp_x(rsp_if.data.unit_x)
);

// File: test/triangle_unit_normal_tb.sv
`timescale 1ns / 1ps
module triangle_unit_normal_tb;
   import tun_pkg::*;

   localparam int MAX_CYCLES = 400000;
   localparam int RANDOM_ITEMS = 550;

   logic clock;
   logic reset;

   tun_req_if req_if ();
   tun_rsp_if rsp_if ();

   triangle_unit_normal dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   typedef struct {
      bit        is_tri;
      bit [9:0]  slot;
      int        x, y, z;
      bit [9:0]  ca, cb, cc;
      bit        typed;
      rsp_word_type want;
   } face_row_type;

   // predictor state
   int            vx_model [VERTEX_DEPTH][3];
   bit            vx_written [VERTEX_DEPTH];
   rsp_word_type  normal_queue [$];
   bit            typed_queue [$];
   rsp_word_type  typed_value_queue [$];

   int            error_count = 0;
   longint        cycle_count = 0;
   int            send_idle_pct;
   int            recv_idle_pct;
   bit            recv_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("triangle_unit_normal_tb NOT OK");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic rsp_word_type face_normal(input bit [9:0] ia, input bit [9:0] ib,
                                                input bit [9:0] ic);
      longint        a [3], b [3], c [3], u [3], v [3], n [3];
      longint unsigned mag [3], m, sum, len, q;
      int            s;
      rsp_word_type  r;
      logic signed [UNIT_W-1:0] comp [3];
      for (int i = 0; i < 3; i++) begin
         a[i] = (ia < VERTEX_DEPTH) ? vx_model[ia][i] : 0;
         b[i] = (ib < VERTEX_DEPTH) ? vx_model[ib][i] : 0;
         c[i] = (ic < VERTEX_DEPTH) ? vx_model[ic][i] : 0;
         u[i] = b[i] - a[i];
         v[i] = c[i] - a[i];
      end
      n[0] = u[1] * v[2] - u[2] * v[1];
      n[1] = u[2] * v[0] - u[0] * v[2];
      n[2] = u[0] * v[1] - u[1] * v[0];
      m = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (n[i] < 0) ? -n[i] : n[i];
         if (mag[i] > m) m = mag[i];
      end
      r = '0;
      if (m == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      s = 0;
      while ((m >> s) >= (64'd1 << 30)) s++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] >>= s;
         sum += mag[i] * mag[i];
      end
      len = root_floor(sum);
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * 16384 + (len >> 1)) / len;
         comp[i] = (n[i] < 0) ? 16'(-q) : 16'(q);
      end
      r.unit_x = comp[0];
      r.unit_y = comp[1];
      r.unit_z = comp[2];
      return r;
   endfunction

   // drive one word; predict on acceptance
   task automatic send_word(input face_row_type row);
      req_word_type w;
      w = '0;
      w.req_type = row.is_tri ? REQ_TRI : REQ_LOAD;
      w.vertex_slot = row.slot;
      w.pos_x = 24'(row.x);
      w.pos_y = 24'(row.y);
      w.pos_z = 24'(row.z);
      w.corner_a = row.ca;
      w.corner_b = row.cb;
      w.corner_c = row.cc;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (row.is_tri) begin
         normal_queue.push_back(face_normal(row.ca, row.cb, row.cc));
         typed_queue.push_back(row.typed);
         typed_value_queue.push_back(row.want);
      end else if (row.slot < VERTEX_DEPTH) begin
         vx_model[row.slot][0] = row.x;
         vx_model[row.slot][1] = row.y;
         vx_model[row.slot][2] = row.z;
         vx_written[row.slot] = 1'b1;
      end
   endtask

   function automatic int rand_coord();
      case ($urandom_range(3))
         0: return $signed($urandom_range(24'hFFFFFF) << 8) >>> 8;
         1: return int'($urandom_range(2000)) - 1000;
         2: return ($urandom_range(1)) ? 8388607 : -8388608;
         default: return int'($urandom_range(200000)) - 100000;
      endcase
   endfunction

   function automatic face_row_type load_row(input bit [9:0] slot, input int x, input int y,
                                             input int z);
      face_row_type r;
      r = '{default: 0};
      r.slot = slot;
      r.x = x;
      r.y = y;
      r.z = z;
      return r;
   endfunction

   function automatic face_row_type tri_row(input bit [9:0] a, input bit [9:0] b,
                                            input bit [9:0] c);
      face_row_type r;
      r = '{default: 0};
      r.is_tri = 1'b1;
      r.ca = a;
      r.cb = b;
      r.cc = c;
      return r;
   endfunction

   function automatic bit [9:0] written_slot();
      bit [9:0] k;
      do k = 10'($urandom_range(VERTEX_DEPTH - 1)); while (!vx_written[k]);
      return k;
   endfunction

   // response checker
   always @(posedge clock) begin
      rsp_word_type got, want, typed_want;
      bit           typed;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.data;
         if (normal_queue.size() == 0) begin
            report_mismatch("unexpected normal word", 0, 0);
         end else begin
            want = normal_queue.pop_front();
            typed = typed_queue.pop_front();
            typed_want = typed_value_queue.pop_front();
            if (typed) want = typed_want;
            if (got.unit_x !== want.unit_x) report_mismatch("unit_x", got.unit_x, want.unit_x);
            if (got.unit_y !== want.unit_y) report_mismatch("unit_y", got.unit_y, want.unit_y);
            if (got.unit_z !== want.unit_z) report_mismatch("unit_z", got.unit_z, want.unit_z);
            if (got.degenerate !== want.degenerate)
               report_mismatch("degenerate", got.degenerate, want.degenerate);
         end
      end
   end

   // receiver ready
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      face_row_type table_rows [$];
      face_row_type r;
      int        sent;
      int        waited;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      recv_hold = 1'b0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // unit axes at origin, extremes, and the top slots
      table_rows.push_back(load_row(0, 0, 0, 0));
      table_rows.push_back(load_row(1, 256, 0, 0));
      table_rows.push_back(load_row(2, 0, 256, 0));
      table_rows.push_back(load_row(1023, 8388607, 8388607, 8388607));
      table_rows.push_back(load_row(1022, -8388608, -8388608, -8388608));
      table_rows.push_back(load_row(3, 8388607, -8388608, 0));
      table_rows.push_back(load_row(4, -8388608, 8388607, 8388607));
      table_rows.push_back(load_row(5, 512, 0, 0));
      r = tri_row(0, 1, 2);
      r.typed = 1'b1;
      r.want = '{unit_x: 16'sd0, unit_y: 16'sd0, unit_z: 16'sd16384, degenerate: 1'b0};
      table_rows.push_back(r);
      r = tri_row(0, 2, 1);
      r.typed = 1'b1;
      r.want = '{unit_x: 16'sd0, unit_y: 16'sd0, unit_z: -16'sd16384, degenerate: 1'b0};
      table_rows.push_back(r);
      // collinear and repeated corners: degenerate
      r = tri_row(0, 1, 5);
      r.typed = 1'b1;
      r.want = '{unit_x: 16'sd0, unit_y: 16'sd0, unit_z: 16'sd0, degenerate: 1'b1};
      table_rows.push_back(r);
      r = tri_row(1, 1, 1);
      r.typed = 1'b1;
      r.want = '{unit_x: 16'sd0, unit_y: 16'sd0, unit_z: 16'sd0, degenerate: 1'b1};
      table_rows.push_back(r);
      table_rows.push_back(tri_row(1023, 1022, 3));
      table_rows.push_back(tri_row(3, 4, 1022));
      table_rows.push_back(tri_row(1022, 4, 1023));
      table_rows.push_back(tri_row(4, 3, 1));
      table_rows.push_back(tri_row(2, 1023, 4));

      send_idle_pct = 32;
      recv_idle_pct = 46;
      foreach (table_rows[i]) send_word(table_rows[i]);
      req_if.valid <= 1'b0;

      // pause until drained
      while (normal_queue.size() != 0) @(posedge clock);

      // hold off the receiver while triangle words wait behind a pending result
      fork
         begin
            recv_hold = 1'b1;
            repeat (1500) @(posedge clock);
            recv_hold = 1'b0;
         end
         for (int k = 0; k < 6; k++)
            send_word(tri_row(written_slot(), written_slot(), written_slot()));
      join

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent == RANDOM_ITEMS / 3) begin
            send_idle_pct = 46;
            recv_idle_pct = 32;
         end else if (sent == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         case ($urandom_range(9))
            0, 1, 2, 3:
               send_word(load_row(10'($urandom_range(1023)), rand_coord(), rand_coord(),
                                  rand_coord()));
            4:
               send_word(tri_row(written_slot(), written_slot(), written_slot()));
            5: begin
               // degenerate: reuse a corner
               r = tri_row(written_slot(), written_slot(), 0);
               r.cc = r.ca;
               send_word(r);
            end
            default:
               send_word(tri_row(written_slot(), written_slot(), written_slot()));
         endcase
         sent++;
      end
      req_if.valid <= 1'b0;

      waited = 0;
      while (normal_queue.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (error_count == 0 && normal_queue.size() == 0) begin
         $display("triangle_unit_normal_tb OK");
      end else begin
         $display("triangle_unit_normal_tb NOT OK");
      end
      $finish;
   end
endmodule

// File: files.f
sv/tun_pkg.sv
sv/tun_if.sv
sv/triangle_unit_normal.sv
sv/tun_check.sv
test/triangle_unit_normal_tb.sv
